FILE: rtl/cla_pkg.sv
// Shared constants, character classes and controller/datapath interface types.
`default_nettype none
package cla_pkg;

  localparam int unsigned LINE_LEN    = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned TAB_STEP    = 5;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W  = ADDR_W + 1;
  localparam int unsigned MOD_W  = $clog2(TAB_STEP);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_CR,
    CLS_NEWLINE,
    CLS_TAB,
    CLS_BS,
    CLS_BELL,
    CLS_PRINT
  } char_cls_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // apply the incoming word to the line
    logic tab_step;     // advance one column of a tab
    logic emit_start;   // begin emitting the line
    logic emit_forced;  // the emission is a full-line break
    logic out_load;     // load the output register from the read data
  } cla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    char_cls_e cls;     // class of the incoming word
    logic      pos_last;  // one more column fills the line
    logic      tab_done;  // this tab step is the final one
    logic      rd_last;   // current read index is the last filled column
    logic      out_free;  // output register can take a result
  } cla_sts_t;

  function automatic char_cls_e classify(input logic [CHAR_W-1:0] ch);
    char_cls_e cls;
    unique case (ch)
      CH_NUL, CH_VT: cls = CLS_IGNORE;
      CH_CR:         cls = CLS_CR;
      CH_LF, CH_FF:  cls = CLS_NEWLINE;
      CH_TAB:        cls = CLS_TAB;
      CH_BS:         cls = CLS_BS;
      CH_BELL:       cls = CLS_BELL;
      default:       cls = CLS_PRINT;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cla_dp.sv
// Datapath: line store, column registers, read index and output register.
`default_nettype none
module cla_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cla_pkg::CHAR_W-1:0]  char_in_i,
  input  wire cla_pkg::cla_cmd_t           cmd_i,
  output cla_pkg::cla_sts_t                sts_o,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [cla_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             out_last_o,
  output logic                             line_empty_o,
  output logic                             line_bell_o,
  output logic                             forced_break_o
);

  logic [cla_pkg::CHAR_W-1:0] mem [cla_pkg::STORE_DEPTH];
  logic [cla_pkg::CHAR_W-1:0] rdata_q;

  logic [cla_pkg::POS_W-1:0]  wp_q, filled_q;
  logic [cla_pkg::MOD_W-1:0]  mod_q;
  logic                       bell_q, forced_q;
  logic [cla_pkg::ADDR_W-1:0] rd_idx_q;

  logic                       out_valid_q, out_last_q, out_empty_q, out_bell_q, out_forced_q;
  logic [cla_pkg::CHAR_W-1:0] out_char_q;

  cla_pkg::char_cls_e         cls;
  logic [cla_pkg::POS_W-1:0]  wp_inc;
  logic [cla_pkg::MOD_W-1:0]  mod_inc, mod_dec;
  logic                       line_empty, rd_last, out_free;
  logic                       we;
  logic [cla_pkg::CHAR_W-1:0] wdata;

  assign cls        = cla_pkg::classify(char_in_i);
  assign wp_inc     = wp_q + cla_pkg::POS_W'(1);
  assign mod_inc    = (mod_q == cla_pkg::MOD_W'(cla_pkg::TAB_STEP - 1)) ?
                      '0 : mod_q + cla_pkg::MOD_W'(1);
  assign mod_dec    = (mod_q == '0) ?
                      cla_pkg::MOD_W'(cla_pkg::TAB_STEP - 1) : mod_q - cla_pkg::MOD_W'(1);
  assign line_empty = (filled_q == '0);
  assign rd_last    = (cla_pkg::POS_W'(rd_idx_q) + cla_pkg::POS_W'(1)) >= filled_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sts_o.cls      = cls;
  assign sts_o.pos_last = (wp_inc == cla_pkg::POS_W'(cla_pkg::LINE_LEN));
  assign sts_o.tab_done = sts_o.pos_last ||
                          (mod_q == cla_pkg::MOD_W'(cla_pkg::TAB_STEP - 1));
  assign sts_o.rd_last  = rd_last;
  assign sts_o.out_free = out_free;

  // Store write: a printable word, or a space for a tab column past the fill.
  always_comb begin
    we    = 1'b0;
    wdata = char_in_i;
    if (cmd_i.accept && cls == cla_pkg::CLS_PRINT) begin
      we = 1'b1;
    end else if (cmd_i.tab_step && wp_q >= filled_q) begin
      we    = 1'b1;
      wdata = cla_pkg::CH_SPACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q[cla_pkg::ADDR_W-1:0]] <= wdata;
    end
    rdata_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      filled_q <= '0;
      mod_q    <= '0;
      bell_q   <= 1'b0;
      forced_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        unique case (cls)
          cla_pkg::CLS_PRINT: begin
            if (wp_q >= filled_q) filled_q <= wp_inc;
            wp_q  <= wp_inc;
            mod_q <= mod_inc;
          end
          cla_pkg::CLS_CR: begin
            wp_q  <= '0;
            mod_q <= '0;
          end
          cla_pkg::CLS_BS: begin
            if (wp_q != '0) begin
              wp_q  <= wp_q - cla_pkg::POS_W'(1);
              mod_q <= mod_dec;
            end
          end
          cla_pkg::CLS_BELL: bell_q <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.tab_step) begin
        if (wp_q >= filled_q) filled_q <= wp_inc;
        wp_q  <= wp_inc;
        mod_q <= mod_inc;
      end
      if (cmd_i.emit_start) begin
        rd_idx_q <= '0;
        forced_q <= cmd_i.emit_forced;
      end
      if (cmd_i.out_load) begin
        rd_idx_q <= rd_idx_q + cla_pkg::ADDR_W'(1);
        if (rd_last) begin
          wp_q     <= '0;
          filled_q <= '0;
          mod_q    <= '0;
          bell_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q   <= line_empty ? '0 : rdata_q;
      out_last_q   <= rd_last;
      out_empty_q  <= line_empty;
      out_bell_q   <= bell_q;
      out_forced_q <= forced_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_last_o     = out_last_q;
  assign line_empty_o   = out_empty_q;
  assign line_bell_o    = out_bell_q;
  assign forced_break_o = out_forced_q;

endmodule
`default_nettype wire

FILE: rtl/cla_ctrl.sv
// Controller: sequences word intake, tab fill and line emission.
`default_nettype none
module cla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cla_pkg::cla_sts_t sts_i,
  output cla_pkg::cla_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TAB  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.cls)
            cla_pkg::CLS_PRINT: begin
              if (sts_i.pos_last) begin
                cmd_o.emit_start  = 1'b1;
                cmd_o.emit_forced = 1'b1;
                state_d           = ST_READ;
              end
            end
            cla_pkg::CLS_TAB:     state_d = ST_TAB;
            cla_pkg::CLS_NEWLINE: begin
              cmd_o.emit_start = 1'b1;
              state_d          = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_TAB: begin
        cmd_o.tab_step = 1'b1;
        if (sts_i.tab_done) begin
          if (sts_i.pos_last) begin
            cmd_o.emit_start  = 1'b1;
            cmd_o.emit_forced = 1'b1;
            state_d           = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: state_d = ST_SEND;
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/console_line_assembler.sv
// Top level of the console line assembler: controller plus datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o | char_in_i
//   out     | output    | out_valid_o / out_stall_i | out_char_o, out_last_o, line_empty_o,
//           |           |                        | line_bell_o, forced_break_o
//
// A printable word, carriage return, backspace, bell or ignored code is applied as it is taken.
// A tab, after its intake, is filled column by column (1 to 5 columns) up to a tab stop or the line end.
// A line is emitted one result at a time, each by a store read and then an output load,
// held longer when the output stalls; the store's single read port sets that pace.
// Reset clears the column, fill count, bell flag and output valid; the store is
// not cleared, since only filled columns are ever put out.
// Input is stalled during a tab fill, and from a line end until the last result is loaded.
`default_nettype none
module console_line_assembler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [cla_pkg::CHAR_W-1:0] char_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [cla_pkg::CHAR_W-1:0]      out_char_o,
  output logic                            out_last_o,
  output logic                            line_empty_o,
  output logic                            line_bell_o,
  output logic                            forced_break_o
);

  // Command and status between sequencer and datapath.
  cla_pkg::cla_cmd_t cmd;
  cla_pkg::cla_sts_t sts;

  cla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath holds the line store and drives the output register directly.
  cla_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_in_i      (char_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_char_o     (out_char_o),
    .out_last_o     (out_last_o),
    .line_empty_o   (line_empty_o),
    .line_bell_o    (line_bell_o),
    .forced_break_o (forced_break_o)
  );

endmodule
`default_nettype wire

FILE: rtl/cla_checker.sv
// Port-level checker for the console line assembler, bound to the top level.
`default_nettype none
module cla_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [cla_pkg::CHAR_W-1:0] out_char_o,
  input wire logic                       out_last_o,
  input wire logic                       line_empty_o,
  input wire logic                       line_bell_o,
  input wire logic                       forced_break_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_char_o) && $stable(out_last_o) &&
      $stable(line_empty_o) && $stable(line_bell_o) && $stable(forced_break_o))
    else $error("output word changed while stalled");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_empty_o |-> out_last_o && out_char_o == '0 && !forced_break_o)
    else $error("empty line marker malformed");

  a_busy_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> in_stall_o)
    else $error("input taken in the middle of a line emission");

  a_flags_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o ##1 out_valid_o |->
      line_bell_o == $past(line_bell_o) && forced_break_o == $past(forced_break_o))
    else $error("line flags changed within a line");

endmodule

bind console_line_assembler cla_checker u_cla_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_char_o     (out_char_o),
  .out_last_o     (out_last_o),
  .line_empty_o   (line_empty_o),
  .line_bell_o    (line_bell_o),
  .forced_break_o (forced_break_o)
);
`default_nettype wire
